// File: rtl/core/oil_paint_window_mode_filter_assert.svh
// Assertion macros for the oil paint filter RTL.
`ifndef OIL_PAINT_WINDOW_MODE_FILTER_ASSERT_SVH
`define OIL_PAINT_WINDOW_MODE_FILTER_ASSERT_SVH
// Property a must imply property b on every clock edge outside reset.
`define OPF_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");
// Property a on one edge must imply property b on the next edge.
`define OPF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`endif

// File: rtl/core/opwmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opwmf_pkg
// Types and constants shared by the oil paint window mode filter.
// ----------------------------------------------------------------------------
package opwmf_pkg;
  localparam int PIX_W = 24;
  localparam int CNT_W = 6;
  localparam int PCT_W = 7;
  localparam logic [PCT_W-1:0] FULL_PCT = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_BLEND,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_INTENSITY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
  } cell_ctl_t;
endpackage

// File: rtl/core/opwmf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opwmf_cell
// One cell of the window chain: holds one window pixel in place, passes a
// second pixel along the ring and keeps per channel the count of moving
// pixels that equal the one held in place.
// ----------------------------------------------------------------------------
module opwmf_cell (
  input  logic                                  clk,
  input  opwmf_pkg::cell_ctl_t                  ctl,
  input  logic                                  load_valid,
  input  logic [opwmf_pkg::PIX_W-1:0]           load_pix,
  input  logic                                  prev_valid,
  input  logic [opwmf_pkg::PIX_W-1:0]           prev_pix,
  output logic                                  valid,
  output logic [opwmf_pkg::PIX_W-1:0]           pix,
  output logic                                  fwd_valid,
  output logic [opwmf_pkg::PIX_W-1:0]           fwd_pix,
  output logic [3*opwmf_pkg::CNT_W-1:0]         counts
);
  import opwmf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      valid <= load_valid;
      pix <= load_pix;
      fwd_valid <= load_valid;
      fwd_pix <= load_pix;
      counts <= '0;
    end else begin
      if (ctl.shift) begin
        fwd_valid <= prev_valid;
        fwd_pix <= prev_pix;
      end
      if (ctl.scan && valid && fwd_valid) begin
        for (int k = 0; k < 3; k++) begin
          if (pix[8*k +: 8] == fwd_pix[8*k +: 8]) begin
            counts[CNT_W*k +: CNT_W] <= counts[CNT_W*k +: CNT_W] + CNT_W'(1);
          end
        end
      end
    end
  end
endmodule

// File: rtl/core/opwmf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opwmf_chain
// Ring of window cells. Each pixel passes every cell once; then the cells
// are swept one per cycle to pick the per-channel mode with lowest value on ties.
// ----------------------------------------------------------------------------
module opwmf_chain #(
  parameter int NCELL = 49,
  parameter int IDX_W = 6
) (
  input  logic                              clk,
  input  opwmf_pkg::cell_ctl_t              ctl,
  input  logic [NCELL-1:0]                  load_valid,
  input  logic [NCELL*opwmf_pkg::PIX_W-1:0] load_pix,
  input  logic                              pick_start,
  input  logic                              pick_en,
  input  logic [IDX_W-1:0]                  pick_idx,
  output logic [opwmf_pkg::PIX_W-1:0]       mode_pix
);
  import opwmf_pkg::*;

  logic [NCELL-1:0] valid;
  logic [NCELL*PIX_W-1:0] pix;
  logic [NCELL-1:0] fwd_valid;
  logic [NCELL*PIX_W-1:0] fwd_pix;
  logic [NCELL*3*CNT_W-1:0] counts;
  logic [3*CNT_W-1:0] best;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int P = (i == 0) ? NCELL - 1 : i - 1;
    opwmf_cell u_cell (
      .clk(clk), .ctl(ctl),
      .load_valid(load_valid[i]), .load_pix(load_pix[PIX_W*i +: PIX_W]),
      .prev_valid(fwd_valid[P]), .prev_pix(fwd_pix[PIX_W*P +: PIX_W]),
      .valid(valid[i]), .pix(pix[PIX_W*i +: PIX_W]),
      .fwd_valid(fwd_valid[i]), .fwd_pix(fwd_pix[PIX_W*i +: PIX_W]),
      .counts(counts[3*CNT_W*i +: 3*CNT_W])
    );
  end

  always_ff @(posedge clk) begin
    if (pick_start) begin
      best <= '0;
      mode_pix <= '0;
    end else if (pick_en && valid[pick_idx]) begin
      for (int k = 0; k < 3; k++) begin
        if (counts[3*CNT_W*pick_idx + CNT_W*k +: CNT_W] > best[CNT_W*k +: CNT_W] ||
            (counts[3*CNT_W*pick_idx + CNT_W*k +: CNT_W] == best[CNT_W*k +: CNT_W] &&
             pix[PIX_W*pick_idx + 8*k +: 8] < mode_pix[8*k +: 8])) begin
          best[CNT_W*k +: CNT_W] <= counts[3*CNT_W*pick_idx + CNT_W*k +: CNT_W];
          mode_pix[8*k +: 8] <= pix[PIX_W*pick_idx + 8*k +: 8];
        end
      end
    end
  end
endmodule

// File: rtl/core/oil_paint_window_mode_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oil_paint_window_mode_filter
// Per-channel window mode over an RGB raster stream, blended with the pixel.
// ----------------------------------------------------------------------------
// Flow: an item that causes a result starts a fetch of the window cells from the
// row store, N = (2*MAX_RADIUS+1)^2 of them, then ring rotation and mode pick, then
// the blend; the result is then offered in ST_OUT. No new item is taken until that
// result is accepted; items causing no result are taken one per cycle while idle.
// Reset is synchronous; counters clear, the row store is left unwritten.
module oil_paint_window_mode_filter #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out, green_out, blue_out
  output logic        m_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import opwmf_pkg::*;
  `include "oil_paint_window_mode_filter_assert.svh"

  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int NCELL = SIDE * SIDE;
  localparam int IDX_W = $clog2(NCELL + 1);
  localparam int CW = $clog2(2 * NCELL + 1);
  localparam int SW = $clog2(SIDE + 1);
  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int XCW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int MW = $clog2(RING * MAX_WIDTH);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int PW = XCW + YW + 1;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [1:0] brush_radius;
  logic [6:0] blend_intensity;

  logic [PIX_W-1:0] row_store [RING*MAX_WIDTH];
  logic [XCW-1:0] in_col, out_col;
  logic [YW-1:0] in_row, out_row;

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [SW-1:0] fr, fc;
  logic [NCELL-1:0] load_valid;
  logic [NCELL*PIX_W-1:0] load_pix;
  logic [PIX_W-1:0] center, rd_data, mode_pix;
  logic [RADW-1:0] rr;
  logic [XCW-1:0] w;
  logic [YW-1:0] h;
  logic [PCT_W-1:0] inten;
  logic cfg_wr, item, frame_done;
  logic [PW-1:0] recv, qd;
  cell_ctl_t ctl;
  logic [1:0] bstep;
  logic [15:0] prod [3];
  logic emit_after;
  logic [PW-1:0] recv_after;
  logic frame_after;

  // Register and derived values
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd640;
      image_height <= 13'd480;
      brush_radius <= 2'd2;
      blend_intensity <= 7'd100;
    end else if (cfg_wr && paddr[1:0] == 2'b00 && paddr[3:2] <= 2'd3) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH: image_width <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        REG_RADIUS: brush_radius <= pwdata[1:0];
        REG_INTENSITY: blend_intensity <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH: prdata = {21'd0, image_width};
      REG_HEIGHT: prdata = {19'd0, image_height};
      REG_RADIUS: prdata = {30'd0, brush_radius};
      REG_INTENSITY: prdata = {25'd0, blend_intensity};
      default: prdata = '0;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  always_comb begin
    if (image_width == 11'd0) w = XCW'(1);
    else if (32'(image_width) > MAX_WIDTH) w = XCW'(MAX_WIDTH);
    else w = XCW'(image_width);
    if (image_height == 13'd0) h = YW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h = YW'(MAX_HEIGHT);
    else h = YW'(image_height);
    rr = (32'(brush_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(brush_radius);
    inten = (blend_intensity > FULL_PCT) ? FULL_PCT : blend_intensity;
  end

  assign s_tready = (state == ST_IDLE) && !rst;
  assign item = s_tvalid && s_tready;

  // Counters compared in linear pixel position (position = row*W + col).
  logic [PW-1:0] in_pos, out_pos;
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_pos <= '0;
      out_pos <= '0;
    end else begin
      if (item && !s_tuser && in_row < h) in_pos <= in_pos + PW'(1);
      if (state == ST_OUT && m_tvalid && m_tready) begin
        if (m_tlast) begin
          in_pos <= '0;
          out_pos <= '0;
        end else out_pos <= out_pos + PW'(1);
      end
    end
  end
  assign recv = in_pos;
  assign qd = out_pos + PW'(rr) * PW'(w) + PW'(rr);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
    end else begin
      if (item && !s_tuser && in_row < h) begin
        row_store[MW'(32'(in_row) % RING * MAX_WIDTH + 32'(in_col))] <= s_tdata;
        if (in_col + XCW'(1) >= w) begin
          in_col <= '0;
          in_row <= in_row + YW'(1);
        end else in_col <= in_col + XCW'(1);
      end
      if (state == ST_OUT && m_tvalid && m_tready) begin
        if (m_tlast) begin
          in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
        end else if (out_col + XCW'(1) >= w) begin
          out_col <= '0;
          out_row <= out_row + YW'(1);
        end else out_col <= out_col + XCW'(1);
      end
    end
  end

  assign frame_done = in_row >= h;

  // Window fetch: cell cnt = fr*SIDE + fc gets offset (dy,dx) = (fr - R, fc - R).
  logic [IDX_W-1:0] fetch_idx;
  logic signed [YW+1:0] fy;
  logic signed [XCW+1:0] fx;
  logic fetch_ok, fetch_ok_d, center_d;
  logic [IDX_W-1:0] fetch_idx_d;
  always_comb begin
    fy = $signed({2'b00, out_row}) + $signed((YW+2)'(fr))
         - $signed((YW+2)'(MAX_RADIUS));
    fx = $signed({2'b00, out_col}) + $signed((XCW+2)'(fc))
         - $signed((XCW+2)'(MAX_RADIUS));
    fetch_idx = IDX_W'(cnt);
    fetch_ok = (cnt < CW'(NCELL)) && fy >= 0 && fx >= 0 &&
               fy < $signed({2'b00, h}) && fx < $signed({2'b00, w}) &&
               (32'(fr) >= MAX_RADIUS - 32'(rr)) &&
               (32'(fr) <= MAX_RADIUS + 32'(rr)) &&
               (32'(fc) >= MAX_RADIUS - 32'(rr)) &&
               (32'(fc) <= MAX_RADIUS + 32'(rr));
  end
  always_ff @(posedge clk) begin
    rd_data <= row_store[MW'((32'(fy[YW-1:0]) % RING) * MAX_WIDTH + 32'(fx[XW-1:0]))];
    fetch_ok_d <= (state == ST_FETCH) && fetch_ok;
    center_d <= (state == ST_FETCH) && (32'(cnt) == NCELL / 2);
    fetch_idx_d <= fetch_idx;
    if (state == ST_IDLE) load_valid <= '0;
    if (fetch_ok_d) begin
      load_valid[fetch_idx_d] <= 1'b1;
      load_pix[PIX_W*fetch_idx_d +: PIX_W] <= rd_data;
    end
    if (center_d) center <= rd_data;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      bstep <= '0;
      fr <= '0;
      fc <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) cnt <= '0;
      else cnt <= cnt + CW'(1);
      bstep <= (state == ST_BLEND) ? bstep + 2'd1 : 2'd0;
      if (state == ST_FETCH) begin
        if (fc == SW'(SIDE - 1)) begin
          fc <= '0;
          fr <= fr + SW'(1);
        end else fc <= fc + SW'(1);
      end else begin
        fr <= '0;
        fc <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item && emit_after) state_next = ST_FETCH;
      ST_FETCH: if (cnt == CW'(NCELL + 1)) state_next = ST_SCAN;
      ST_SCAN: if (cnt == CW'(2 * NCELL)) state_next = ST_BLEND;
      ST_BLEND: if (bstep == 2'd2) state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Emission is decided on the counters after this item updates them.
  always_comb begin
    recv_after = recv + PW'(!s_tuser && !frame_done);
    frame_after = frame_done ||
      (!s_tuser && in_col + XCW'(1) >= w && in_row + YW'(1) >= h);
    emit_after = frame_after || (recv_after >= qd + PW'(1));
  end

  // Scan: load the cells, then rotate them while counting; controls below.
  always_comb begin
    ctl = '0;
    if (state == ST_SCAN) begin
      ctl.load = (cnt == '0);
      ctl.scan = (cnt != '0) && (cnt <= CW'(NCELL));
      ctl.shift = ctl.scan;
    end
  end

  opwmf_chain #(.NCELL(NCELL), .IDX_W(IDX_W)) u_chain (
    .clk(clk), .ctl(ctl),
    .load_valid(load_valid), .load_pix(load_pix),
    .pick_start(state == ST_SCAN && cnt == CW'(NCELL)),
    .pick_en(state == ST_SCAN && cnt > CW'(NCELL)),
    .pick_idx(IDX_W'(cnt - CW'(NCELL + 1))),
    .mode_pix(mode_pix)
  );

  // Blend: product registered, then constant division by 100.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (bstep == 2'd0)
        prod[k] <= 16'(inten) * 16'(mode_pix[8*k +: 8]) +
                   16'(FULL_PCT - inten) * 16'(center[8*k +: 8]);
      if (bstep == 2'd1)
        m_tdata[8*k +: 8] <= 8'(32'(prod[k]) * 32'd5243 >> 19);
    end
    if (bstep == 2'd1)
      m_tlast <= (out_row + YW'(1) >= h) && (out_col + XCW'(1) >= w);
  end
  assign m_tvalid = (state == ST_OUT);

  `OPF_ASSERT_IMPLY(a_no_accept_busy, clk, rst, state != ST_IDLE, !s_tready)
  `OPF_ASSERT_NEXT(a_out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `OPF_ASSERT_NEXT(a_last_clears, clk, rst, m_tvalid && m_tready && m_tlast,
                   out_pos == '0)
endmodule

// File: sim/tb_oil_paint_window_mode_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oil_paint_window_mode_filter
// Self-checking bench for the oil paint window mode filter. Frames of RGB
// pixels are streamed in with random gaps and back-pressure while a local
// model of the window mode and blend predicts every output pixel.
// ----------------------------------------------------------------------------
module tb_oil_paint_window_mode_filter;
  import opwmf_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int MAX_R = 3;
  localparam int RING = 2 * MAX_R + 2;
  localparam int SETTLE = 400;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } out_pix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // red_in, green_in, blue_in
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red_out, green_out, blue_out
  logic        m_tlast;        // frame_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  oil_paint_window_mode_filter i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [10:0] cfg_width = 11'd640;
  logic [12:0] cfg_height = 13'd480;
  logic [1:0]  cfg_radius = 2'd2;
  logic [6:0]  cfg_intensity = 7'd100;
  logic [23:0] line_ring [RING][MAX_W];
  int unsigned in_col, in_row, out_col, out_row;

  out_pix_t expected_pix[$];
  int mismatches = 0;
  int cycles = 0;
  int items_sent = 0;
  int pixels_out = 0;
  int frames_done = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  function automatic int unsigned eff_w();
    if (cfg_width == 0) return 1;
    return (cfg_width > MAX_W) ? MAX_W : cfg_width;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_height == 0) return 1;
    return (cfg_height > MAX_H) ? MAX_H : cfg_height;
  endfunction

  function automatic logic [7:0] blend_channel(int cnt, logic [23:0] win[49], int sh,
                                               logic [23:0] centre);
    int hist[256];
    int best, best_n, pct, orig;
    for (int v = 0; v < 256; v++) hist[v] = 0;
    for (int n = 0; n < cnt; n++) hist[(win[n] >> sh) & 8'hFF]++;
    best = 0;
    best_n = 0;
    for (int v = 0; v < 256; v++) begin
      if (hist[v] > best_n) begin
        best_n = hist[v];
        best = v;
      end
    end
    pct = (cfg_intensity > 100) ? 100 : cfg_intensity;
    orig = (centre >> sh) & 8'hFF;
    return 8'((pct * best + (100 - pct) * orig) / 100);
  endfunction

  // Advances the model by one accepted item and queues any output pixel.
  task automatic filter_predict(input logic kind, input logic [23:0] rgb);
    int unsigned w, h, r, cnt;
    longint unsigned recv, q, d;
    logic [23:0] win[49];
    logic [23:0] centre;
    int y, x;
    out_pix_t p;
    w = eff_w();
    h = eff_h();
    r = cfg_radius;
    if (!kind && in_row < h) begin
      line_ring[in_row % RING][in_col % MAX_W] = {rgb[7:0], rgb[15:8], rgb[23:16]};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    recv = longint'(in_row) * w + in_col;
    q = longint'(out_row) * w + out_col;
    d = longint'(r) * w + r;
    if (!(in_row >= h || recv >= q + d + 1)) return;
    cnt = 0;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      y = int'(out_row) + dy;
      if (y < 0 || y >= int'(h)) continue;
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        x = int'(out_col) + dx;
        if (x < 0 || x >= int'(w)) continue;
        win[cnt] = line_ring[y % RING][x % MAX_W];
        cnt++;
      end
    end
    centre = line_ring[out_row % RING][out_col % MAX_W];
    p.red = blend_channel(cnt, win, 16, centre);
    p.green = blend_channel(cnt, win, 8, centre);
    p.blue = blend_channel(cnt, win, 0, centre);
    p.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_pix.push_back(p);
    if (p.last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frames_done++;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("tb_oil_paint_window_mode_filter failed");
      $finish;
    end
  end

  // Inputs only move at the rising edge, so the falling edge sees settled values.
  always @(negedge clk) begin
    out_pix_t e;
    if (!rst && m_tvalid && m_tready) begin
      pixels_out++;
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output pixel %h last %b", m_tdata, m_tlast);
      end else begin
        e = expected_pix.pop_front();
        if (m_tdata[7:0] !== e.red || m_tdata[15:8] !== e.green ||
            m_tdata[23:16] !== e.blue || m_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected r%h g%h b%h last %b, got r%h g%h b%h last %b",
                     e.red, e.green, e.blue, e.last,
                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  task automatic send_item(input logic kind, input logic [23:0] rgb);
    logic rdy;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= rgb;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    filter_predict(kind, rgb);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    wait_drained();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: cfg_width = val[10:0];
      REG_HEIGHT: cfg_height = val[12:0];
      REG_RADIUS: cfg_radius = val[1:0];
      REG_INTENSITY: cfg_intensity = val[6:0];
      default: ;
    endcase
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic set_config(int w, int h, int r, int inten);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_RADIUS, r);
    reg_write(REG_INTENSITY, inten);
  endtask

  task automatic drain_frame();
    while (in_row >= eff_h()) send_item(1'($urandom_range(1)), 24'($urandom));
  endtask

  task automatic test_directed();
    set_config(4, 3, 1, 100);
    send_item(1'b1, 24'h0);
    for (int n = 0; n < 12; n++)
      send_item(1'b0, (n % 3 == 0) ? 24'hFFFFFF : ((n % 3 == 1) ? 24'h000000 : 24'h80FF01));
    send_item(1'b0, 24'h123456);
    drain_frame();
    set_config(3, 2, 0, 0);
    for (int n = 0; n < 6; n++) send_item(1'b0, 24'($urandom));
    drain_frame();
    set_config(0, 0, 3, 127);
    send_item(1'b0, 24'hA5C3FF);
    drain_frame();
  endtask

  task automatic test_wide_row();
    set_config(2047, 1, 0, 57);
    for (int n = 0; n < MAX_W; n++)
      send_item(1'b0, (n % 5 < 2) ? 24'h10FF7F : 24'($urandom));
    drain_frame();
  endtask

  task automatic test_tall_abort();
    set_config(1, 4096, 3, 33);
    for (int n = 0; n < 20; n++) send_item(1'b0, 24'($urandom));
    set_config(2, 8191, 1, 100);
    for (int n = 0; n < 10; n++) send_item(1'b0, 24'($urandom));
    reg_write(REG_HEIGHT, 2);
  endtask

  task automatic test_random(int quota, bit hold_off);
    int goal, w, h, npix;
    logic [23:0] palette[4];
    bit paused;
    goal = items_sent + quota;
    paused = 0;
    while (items_sent < goal) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 16) : $urandom_range(12, 1);
      h = $urandom_range(8, 1);
      set_config(w, h, $urandom_range(3),
                 ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 0 : 127)
                                          : $urandom_range(100));
      for (int k = 0; k < 4; k++) palette[k] = 24'($urandom);
      npix = w * h;
      if ($urandom_range(9) == 0) npix = $urandom_range(npix);
      for (int n = 0; n < npix; n++) begin
        if ($urandom_range(19) == 0) send_item(1'b1, 24'($urandom));
        if (hold_off && !paused && n == npix / 2) begin
          paused = 1;
          s_tvalid <= 1'b0;
          do @(posedge clk); while (expected_pix.size() != 0);
        end
        send_item(1'b0, ($urandom_range(3) == 0) ? 24'($urandom)
                                                 : palette[$urandom_range(3)]);
      end
      if (npix == w * h) drain_frame();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_wide_row();
    test_tall_abort();
    send_gap_pct = 16; recv_gap_pct = 83;
    test_random(160, 1);
    send_gap_pct = 83; recv_gap_pct = 16;
    test_random(160, 0);
    send_gap_pct = 0; recv_gap_pct = 0;
    test_random(160, 0);
    wait_drained();
    $display("Streamed %0d items over %0d frames and checked %0d output pixels,",
             items_sent, frames_done, pixels_out);
    $display("with %0d mismatches across radii, intensities and frame shapes.", mismatches);
    if (mismatches == 0 && expected_pix.size() == 0)
      $display("tb_oil_paint_window_mode_filter passed");
    else
      $display("tb_oil_paint_window_mode_filter failed");
    $finish;
  end
endmodule
